// ----- rtl/core/ukt_pkg.sv -----
// shared types and constants for the unique key table engine
// no dependencies; imported by ukt_cell, unique_key_table_engine and the testbench
package ukt_pkg;

    localparam int KEY_BITS      = 32;
    localparam int IN_PL_BITS    = 64;
    localparam int OP_BITS       = 2;
    localparam int STATUS_BITS   = 3;
    localparam int POS_BITS      = 7;
    localparam int COUNT_BITS    = 8;
    localparam int S_TDATA_BITS  = 96;
    localparam int M_TDATA_BITS  = 80;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_UPDATE = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_MATCH  = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

    typedef struct packed {
        logic compare;
        logic insert;
        logic update;
        logic remove;
    } t_cell_ctl;

endpackage

// ----- rtl/core/ukt_cell.sv -----
// one table slot: key and payload storage, key compare, shift toward lower slot
// depends on ukt_pkg
module ukt_cell #(
    parameter int IDX = 0,
    parameter int PW  = 64,
    parameter int CW  = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ukt_pkg::t_cell_ctl           i_ctl,
    input  logic [CW-1:0]                i_count,
    input  logic [ukt_pkg::KEY_BITS-1:0] i_key,
    input  logic [PW-1:0]                i_payload,
    input  logic [ukt_pkg::KEY_BITS-1:0] i_nxt_key,
    input  logic [PW-1:0]                i_nxt_payload,
    input  logic                         i_seen,
    output logic [ukt_pkg::KEY_BITS-1:0] o_key,
    output logic [PW-1:0]                o_payload,
    output logic                         o_match,
    output logic                         o_seen
);
    import ukt_pkg::*;

    logic [KEY_BITS-1:0] r_key;
    logic [PW-1:0]       r_payload;
    logic                r_match;
    logic                w_valid;
    logic                w_here;

    assign w_valid = CW'(IDX) < i_count;
    assign w_here  = CW'(IDX) == i_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.compare) begin
            r_match <= w_valid && (r_key == i_key);
        end
    end

    // prefix of matches from slot 0 up: every slot at or after the hit shifts down
    assign o_seen = i_seen | r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert && w_here) begin
            r_key     <= i_key;
            r_payload <= i_payload;
        end else if (i_ctl.update && r_match) begin
            r_payload <= i_payload;
        end else if (i_ctl.remove && o_seen) begin
            r_key     <= i_nxt_key;
            r_payload <= i_nxt_payload;
        end
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;
    assign o_match   = r_match;

endmodule

// ----- rtl/core/unique_key_table_engine.sv -----
// unique key table engine: an accepted request is registered, the match state runs
// the parallel key compare in the cell row, the commit state resolves the hit,
// writes or compacts the cells and the result register, and can take a new request
// as it fires; a result left on the output register holds the commit until taken
// reset (synchronous, active low) empties the table; slot contents are not cleared
module unique_key_table_engine #(
    parameter int TABLE_DEPTH  = 128,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key[31:0], payload[95:32]
    input  logic [ukt_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
    // kind[1:0]
    input  logic [ukt_pkg::OP_BITS-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // position[6:0], found_payload[70:7], entry_count[78:71], zero[79]
    output logic [ukt_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
    // status[2:0]
    output logic [ukt_pkg::STATUS_BITS-1:0]  m_axis_tuser
);
    import ukt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = PAYLOAD_BITS;

    t_state              r_state, n_state;
    t_op                 r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [PW-1:0]       r_payload;
    logic [CW-1:0]       r_count, n_count;

    logic                   r_m_tvalid;
    t_status                r_o_status, n_status;
    logic [POS_BITS-1:0]    r_o_pos;
    logic [IN_PL_BITS-1:0]  r_o_found;
    logic [COUNT_BITS-1:0]  r_o_count;

    t_cell_ctl              w_ctl;
    logic [KEY_BITS-1:0]    w_key   [TABLE_DEPTH];
    logic [PW-1:0]          w_pl    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_match;
    logic [TABLE_DEPTH:0]   w_seen;

    logic                w_found;
    logic [IW-1:0]       w_hit_idx;
    logic [PW-1:0]       w_hit_pl;
    logic                w_full;
    logic                w_out_free;
    logic                w_fire;
    logic                w_accept;
    logic [IW-1:0]       n_pos_idx;
    logic [PW-1:0]       n_found;
    logic                n_ins, n_upd, n_rem;

    logic [IW+POS_BITS-1:0]   w_pos_ext;
    logic [CW+COUNT_BITS-1:0] w_cnt_ext;
    logic [PW+IN_PL_BITS-1:0] w_pl_ext;

    assign w_out_free    = !r_m_tvalid || m_axis_tready;
    assign w_fire        = (r_state == S_COMMIT) && w_out_free;
    assign s_axis_tready = (r_state == S_IDLE) || w_fire;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_MATCH;
            S_MATCH:  n_state = S_COMMIT;
            S_COMMIT: if (w_fire) n_state = w_accept ? S_MATCH : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_fire) r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= t_op'(s_axis_tuser);
            r_key     <= s_axis_tdata[KEY_BITS-1:0];
            r_payload <= s_axis_tdata[KEY_BITS +: PW];
        end
    end

    // cell row
    assign w_seen[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            logic [KEY_BITS-1:0] w_nk;
            logic [PW-1:0]       w_np;
            if (g == TABLE_DEPTH - 1) begin : g_last
                assign w_nk = '0;
                assign w_np = '0;
            end else begin : g_mid
                assign w_nk = w_key[g+1];
                assign w_np = w_pl[g+1];
            end
            ukt_cell #(
                .IDX (g),
                .PW  (PW),
                .CW  (CW)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_count       (r_count),
                .i_key         (r_key),
                .i_payload     (r_payload),
                .i_nxt_key     (w_nk),
                .i_nxt_payload (w_np),
                .i_seen        (w_seen[g]),
                .o_key         (w_key[g]),
                .o_payload     (w_pl[g]),
                .o_match       (w_match[g]),
                .o_seen        (w_seen[g+1])
            );
        end
    endgenerate

    // keys are unique, so at most one match bit is set and an or-tree resolves it
    always_comb begin
        w_hit_idx = '0;
        w_hit_pl  = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_match[i]) begin
                w_hit_idx = w_hit_idx | IW'(i);
                w_hit_pl  = w_hit_pl | w_pl[i];
            end
        end
    end

    assign w_found = |w_match;
    assign w_full  = r_count == CW'(TABLE_DEPTH);

    always_comb begin
        n_status  = ST_OK;
        n_pos_idx = '0;
        n_found   = '0;
        n_count   = r_count;
        n_ins     = 1'b0;
        n_upd     = 1'b0;
        n_rem     = 1'b0;
        if (r_op == OP_INSERT) begin
            if (w_found) begin
                n_status = ST_DUPLICATE;
            end else if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_pos_idx = r_count[IW-1:0];
                n_count   = r_count + CW'(1);
                n_ins     = 1'b1;
            end
        end else if (r_count == '0) begin
            n_status = ST_EMPTY;
        end else if (!w_found) begin
            n_status = ST_NOT_FOUND;
        end else begin
            n_pos_idx = w_hit_idx;
            unique case (r_op)
                OP_LOOKUP: n_found = w_hit_pl;
                OP_UPDATE: n_upd   = 1'b1;
                OP_REMOVE: begin
                    n_rem   = 1'b1;
                    n_count = r_count - CW'(1);
                end
                default:   n_found = '0;
            endcase
        end
    end

    always_comb begin
        w_ctl.compare = r_state == S_MATCH;
        w_ctl.insert  = w_fire && n_ins;
        w_ctl.update  = w_fire && n_upd;
        w_ctl.remove  = w_fire && n_rem;
    end

    assign w_pos_ext = {{POS_BITS{1'b0}}, n_pos_idx};
    assign w_cnt_ext = {{COUNT_BITS{1'b0}}, n_count};
    assign w_pl_ext  = {{IN_PL_BITS{1'b0}}, n_found};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_fire) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_o_status <= n_status;
            r_o_pos    <= w_pos_ext[POS_BITS-1:0];
            r_o_found  <= w_pl_ext[IN_PL_BITS-1:0];
            r_o_count  <= w_cnt_ext[COUNT_BITS-1:0];
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {1'b0, r_o_count, r_o_found, r_o_pos};
    assign m_axis_tuser  = r_o_status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one slot matched the key");

    a_accept_to_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_MATCH)
        else $error("accepted request did not start a compare");

    a_no_accept_in_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MATCH |-> !s_axis_tready)
        else $error("request taken during compare");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_count))
        else $error("entry count changed outside commit");

endmodule

// ----- tb/unique_key_table_engine_tb.sv -----
// testbench for unique_key_table_engine: directed and phased random table operations
// a scoreboard class predicts every result from its own copy of the table
// depends on ukt_pkg and the engine rtl only
module unique_key_table_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ukt_pkg::*;

    localparam int TABLE_DEPTH  = 128;
    localparam int RANDOM_ITEMS = 950;
    localparam int CHUNK_ITEMS  = 50;

    typedef struct {
        t_status     status;
        logic [6:0]  position;
        logic [63:0] found_payload;
        logic [7:0]  entry_count;
    } t_table_result;

    class table_scoreboard;
        logic [31:0]   keys [TABLE_DEPTH];
        logic [63:0]   payloads [TABLE_DEPTH];
        int            live_entries;
        t_table_result expected_q [$];
        int            errors;

        function new();
            live_entries = 0;
            errors = 0;
        endfunction

        function int find_slot(logic [31:0] k);
            for (int s = 0; s < live_entries; s++) begin
                if (keys[s] === k) return s;
            end
            return -1;
        endfunction

        function logic [31:0] pick_present_key();
            return keys[$urandom_range(live_entries - 1)];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(t_op kind, logic [31:0] k, logic [63:0] pl);
            t_table_result r;
            int hit;
            r.status = ST_OK;
            r.position = '0;
            r.found_payload = '0;
            hit = find_slot(k);
            if (kind == OP_INSERT) begin
                if (hit >= 0) begin
                    r.status = ST_DUPLICATE;
                end else if (live_entries >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    r.position = live_entries[6:0];
                    keys[live_entries] = k;
                    payloads[live_entries] = pl;
                    live_entries++;
                end
            end else if (live_entries == 0) begin
                r.status = ST_EMPTY;
            end else if (hit < 0) begin
                r.status = ST_NOT_FOUND;
            end else begin
                r.position = hit[6:0];
                case (kind)
                    OP_LOOKUP: r.found_payload = payloads[hit];
                    OP_UPDATE: payloads[hit] = pl;
                    default: begin
                        for (int j = hit; j + 1 < live_entries; j++) begin
                            keys[j] = keys[j + 1];
                            payloads[j] = payloads[j + 1];
                        end
                        live_entries--;
                    end
                endcase
            end
            r.entry_count = live_entries[7:0];
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (act_v !== exp_v) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_BITS-1:0] tdata, logic [STATUS_BITS-1:0] tuser);
            t_table_result r;
            if (expected_q.size() == 0) begin
                $error("result with no request pending: status %0d", tuser);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            compare_field("status", 64'(r.status), 64'(tuser));
            compare_field("position", 64'(r.position), 64'(tdata[6:0]));
            compare_field("found_payload", r.found_payload, tdata[70:7]);
            compare_field("entry_count", 64'(r.entry_count), 64'(tdata[78:71]));
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata;
    logic [OP_BITS-1:0]      s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [M_TDATA_BITS-1:0] m_axis_tdata;
    logic [STATUS_BITS-1:0]  m_axis_tuser;

    table_scoreboard sb;
    bit no_idle;
    bit hold_off_req;

    unique_key_table_engine #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .PAYLOAD_BITS (64)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the request is taken
    task automatic send_request(t_op kind, logic [31:0] key, logic [63:0] pl);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 10) ? $urandom_range(3, 1) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pl, key};
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(t_op'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[95:32]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (no_idle) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= 10);
            end
        end
    end

    initial begin
        int ins_pct;
        int rem_pct;
        int roll;
        t_op kind;
        logic [31:0] key;
        logic [63:0] pl;
        // m mixed, f fill, d drain, one letter per chunk
        string schedule;
        schedule = "mffffddddddmfffdddm";
        sb = new();
        no_idle = 1'b0;
        hold_off_req = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_INSERT;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_request(OP_LOOKUP, 32'h0000_0000, 64'h0);
        send_request(OP_UPDATE, 32'h0000_0005, 64'hffff_ffff_ffff_ffff);
        send_request(OP_REMOVE, 32'hffff_ffff, 64'h0);
        send_request(OP_INSERT, 32'h8000_0000, 64'hffff_ffff_ffff_ffff);
        send_request(OP_INSERT, 32'h7fff_ffff, 64'h0);
        send_request(OP_INSERT, 32'h0000_0000, 64'h5555_5555_5555_5555);
        send_request(OP_INSERT, 32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa);
        send_request(OP_INSERT, 32'h8000_0000, 64'h1234_5678_9abc_def0);
        send_request(OP_LOOKUP, 32'h7fff_ffff, 64'hffff_ffff_ffff_ffff);
        send_request(OP_LOOKUP, 32'h0000_1234, 64'h0);
        send_request(OP_UPDATE, 32'h0000_0000, {$urandom, $urandom});
        send_request(OP_LOOKUP, 32'h0000_0000, 64'h0);
        send_request(OP_UPDATE, 32'h0000_4321, 64'h0);
        send_request(OP_REMOVE, 32'h0000_4321, 64'h0);
        send_request(OP_REMOVE, 32'h7fff_ffff, 64'h0);
        send_request(OP_LOOKUP, 32'hffff_ffff, 64'h0);
        send_request(OP_REMOVE, 32'hffff_ffff, 64'h0);
        send_request(OP_LOOKUP, 32'h8000_0000, 64'h0);
        send_request(OP_REMOVE, 32'h8000_0000, 64'h0);
        send_request(OP_LOOKUP, 32'h0000_0000, 64'h0);
        send_request(OP_REMOVE, 32'h0000_0000, 64'h0);
        send_request(OP_LOOKUP, 32'h0000_0000, 64'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case (schedule[(n / CHUNK_ITEMS) % schedule.len()])
                "f": begin ins_pct = 80; rem_pct = 5; end
                "d": begin ins_pct = 10; rem_pct = 70; end
                default: begin ins_pct = 35; rem_pct = 25; end
            endcase
            if (n == 400) hold_off_req = 1'b1;
            no_idle = (n >= 600 && n < 750);
            roll = $urandom_range(99);
            if (roll < ins_pct) kind = OP_INSERT;
            else if (roll < ins_pct + rem_pct) kind = OP_REMOVE;
            else kind = $urandom_range(1) ? OP_LOOKUP : OP_UPDATE;
            if (sb.live_entries > 0 &&
                $urandom_range(99) < ((kind == OP_INSERT) ? 15 : 80))
                key = sb.pick_present_key();
            else
                key = $urandom;
            if ($urandom_range(99) < 4) begin
                case ($urandom_range(3))
                    0: key = 32'h8000_0000;
                    1: key = 32'h7fff_ffff;
                    2: key = 32'h0000_0000;
                    default: key = 32'hffff_ffff;
                endcase
            end
            pl = {$urandom, $urandom};
            send_request(kind, key, pl);
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (sb.pending() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/ukt_pkg.sv
rtl/core/ukt_cell.sv
rtl/core/unique_key_table_engine.sv
tb/unique_key_table_engine_tb.sv
